FILE: design/uar_pkg.sv
package uar_pkg;

    // Width of the number to convert
    localparam int VALUE_BITS = 32;
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;

    // Radix limits and character codes
    localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_BITS-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0]  CHAR_A     = 7'd65;
    localparam logic [CHAR_BITS-1:0]  CHAR_NINE  = 7'd57;
    localparam logic [CHAR_BITS-1:0]  CHAR_Z     = 7'd90;

    // Input request
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
    } req_t;

    // Result: one digit character
    typedef struct packed {
        logic [CHAR_BITS-1:0] digit_char;
        logic                 last_digit;
    } rsp_t;

    // Divider command and result
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_BITS-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic [RADIX_BITS-1:0] rem;
    } div_res_t;

endpackage

FILE: design/unsigned_to_ascii_radix.sv
// Converts one unsigned value to ASCII digits in radix 2..36 (radix below 2
// acts as 2, above 36 as 36), most significant digit first, with last_digit
// set on the final character. One request is handled at a time: each digit
// is produced by a division in the bit-serial divider, the digits are then
// popped from a shift stack at one per cycle while the output is ready.
module unsigned_to_ascii_radix (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  uar_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output uar_pkg::rsp_t m_rsp
);

    localparam int VB    = uar_pkg::VALUE_BITS;
    localparam int RB    = uar_pkg::RADIX_BITS;
    localparam int CB    = uar_pkg::CHAR_BITS;
    localparam int DCN_W = $clog2(VB + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

    state_t            state_reg, state_next;
    logic [DCN_W-1:0]  dcnt_reg, dcnt_next;
    logic [RB-1:0]     stack_reg [VB];
    logic [RB-1:0]     stack_next [VB];
    logic [RB-1:0]     radix_clamped;
    logic              s_fire, m_fire, push, pop;
    uar_pkg::div_cmd_t div_cmd;
    uar_pkg::div_res_t div_res;

    function automatic logic [CB-1:0] to_char(input logic [RB-1:0] d);
        if (d < uar_pkg::DEC_DIGITS)
            return uar_pkg::CHAR_ZERO + CB'(d);
        else
            return uar_pkg::CHAR_A + CB'(d - uar_pkg::DEC_DIGITS);
    endfunction

    // Clamp radix into the supported range
    always_comb begin
        priority if (s_req.radix < uar_pkg::RADIX_MIN) begin
            radix_clamped = uar_pkg::RADIX_MIN;
        end else if (s_req.radix > uar_pkg::RADIX_MAX) begin
            radix_clamped = uar_pkg::RADIX_MAX;
        end else begin
            radix_clamped = s_req.radix;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign push    = (state_reg == ST_DIV) && div_res.done;
    assign pop     = m_fire;

    // Hold the divisor across digits: only load it on a new request
    logic [RB-1:0] radix_reg;
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            radix_reg <= radix_clamped;
        end
    end

    // Start the divider on a new request, or again while the quotient is nonzero
    assign div_cmd.start    = s_fire || (push && (div_res.quot != '0));
    assign div_cmd.dividend = s_fire ? s_req.value : div_res.quot;
    assign div_cmd.divisor  = s_fire ? radix_clamped : radix_reg;

    uar_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .res     (div_res)
    );

    // Digit stack: push remainders, pop most significant first
    always_comb begin
        for (int i = 0; i < VB; i++) begin
            stack_next[i] = stack_reg[i];
        end
        if (push) begin
            stack_next[0] = div_res.rem;
            for (int i = 1; i < VB; i++) begin
                stack_next[i] = stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < VB - 1; i++) begin
                stack_next[i] = stack_reg[i+1];
            end
            stack_next[VB-1] = '0;
        end
    end

    // Sequence division and emission
    always_comb begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_DIV;
                    dcnt_next  = '0;
                end
            end
            ST_DIV: begin
                if (push) begin
                    dcnt_next = dcnt_reg + 1'b1;
                    if (div_res.quot == '0) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (pop) begin
                    dcnt_next = dcnt_reg - 1'b1;
                    if (dcnt_reg == DCN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
        end
        for (int i = 0; i < VB; i++) begin
            stack_reg[i] <= stack_next[i];
        end
    end

    assign m_rsp.digit_char = to_char(stack_reg[0]);
    assign m_rsp.last_digit = (dcnt_reg == DCN_W'(1));

    // The divisor register is observed here so a slip in loading shows up
    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (radix_reg >= uar_pkg::RADIX_MIN) &&
                                  (radix_reg <= uar_pkg::RADIX_MAX))
        else $error("divisor out of range during division");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("request taken while digits are pending");

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (dcnt_reg != '0))
        else $error("emitting with an empty digit stack");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside of division");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_rsp.last_digit) |=> s_ready)
        else $error("not ready after last digit");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_rsp.digit_char >= uar_pkg::CHAR_ZERO) &&
                     (m_rsp.digit_char <= uar_pkg::CHAR_NINE)) ||
                    ((m_rsp.digit_char >= uar_pkg::CHAR_A) &&
                     (m_rsp.digit_char <= uar_pkg::CHAR_Z)))
        else $error("digit character out of range");

endmodule

FILE: design/uar_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module uar_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  uar_pkg::div_cmd_t cmd,
    output uar_pkg::div_res_t res
);

    localparam int VB    = uar_pkg::VALUE_BITS;
    localparam int RB    = uar_pkg::RADIX_BITS;
    localparam int CNT_W = $clog2(VB);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VB-1:0]     quot_reg, quot_next;
    logic [RB-1:0]     rem_reg, rem_next;
    logic [RB-1:0]     dvs_reg, dvs_next;
    logic [RB:0]       trial;
    logic              qbit;

    // Shift next dividend bit into the partial remainder and compare
    assign trial = {rem_reg, quot_reg[VB-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VB - 1);
            quot_next = cmd.dividend;
            rem_next  = '0;
            dvs_next  = cmd.divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[VB-2:0], qbit};
            rem_next  = qbit ? RB'(trial - {1'b0, dvs_reg}) : trial[RB-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

FILE: dv/tb_unsigned_to_ascii_radix.sv
`timescale 1ns / 1ps

module tb_unsigned_to_ascii_radix;
    import uar_pkg::*;

    // No progress on either channel for this long means the block hung
    localparam int STALL_LIMIT = 8000;
    localparam int RANDOM_REQUESTS = 210;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_req;
    logic m_valid;
    logic m_ready;
    rsp_t m_rsp;

    rsp_t expected_digits[$];
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    bit   tx_throttle = 1'b1;
    bit   rx_throttle = 1'b1;

    unsigned_to_ascii_radix dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly short pauses, now and then a long one
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 88) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Convert a request into the digit characters it should produce
    function automatic void predict_digits(req_t req);
        logic [VALUE_BITS-1:0] rest;
        logic [RADIX_BITS-1:0] base;
        int unsigned           digit;
        logic [CHAR_BITS-1:0]  chars[$];
        rsp_t                  rsp;
        base = req.radix;
        if (base < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (base > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        rest = req.value;
        // collect least significant digit first, emit in reverse
        do begin
            digit = rest % base;
            if (digit < DEC_DIGITS) begin
                chars.push_front(CHAR_BITS'(CHAR_ZERO + digit));
            end else begin
                chars.push_front(CHAR_BITS'(CHAR_A + digit - DEC_DIGITS));
            end
            rest = rest / base;
        end while (rest != 0);
        foreach (chars[i]) begin
            rsp.digit_char = chars[i];
            rsp.last_digit = (i == chars.size() - 1);
            expected_digits.push_back(rsp);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare one accepted digit against the oldest expected one
    task automatic check_digit(input rsp_t got);
        rsp_t want;
        if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                                      got.digit_char, got.last_digit));
            return;
        end
        want = expected_digits.pop_front();
        if (got.digit_char !== want.digit_char)
            report_mismatch($sformatf("digit_char got %0d want %0d",
                                      got.digit_char, want.digit_char));
        if (got.last_digit !== want.last_digit)
            report_mismatch($sformatf("last_digit got %0b want %0b (char %0d)",
                                      got.last_digit, want.last_digit, want.digit_char));
    endtask

    // Predict on each accepted request, check each accepted digit
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_digits(s_req);
            if (m_valid && m_ready) check_digit(m_rsp);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("unsigned_to_ascii_radix verification failed");
            $finish;
        end
    end

    // Result side: drop ready for random stretches while throttled
    initial begin
        int hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                hold = idle_length();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic [VALUE_BITS-1:0] value,
                                input logic [RADIX_BITS-1:0] radix);
        int gap;
        req_t req;
        gap = tx_throttle ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        req.value = value;
        req.radix = radix;
        s_valid <= 1'b1;
        s_req   <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic test_zero_value();
        send_request('0, 6'd2);
        send_request('0, 6'd10);
        send_request('0, 6'd36);
        send_request('0, 6'd0);
    endtask

    task automatic test_value_extremes();
        send_request('1, 6'd2);
        send_request('1, 6'd10);
        send_request('1, 6'd16);
        send_request('1, 6'd36);
        send_request(32'd1, 6'd2);
        send_request(32'h8000_0000, 6'd2);
        send_request(32'hAAAA_AAAA, 6'd16);
        send_request(32'h5555_5555, 6'd8);
    endtask

    // Radix below two acts as binary, above thirty-six as base 36
    task automatic test_radix_clamp();
        send_request(32'h0000_1234, 6'd0);
        send_request(32'h0000_1234, 6'd1);
        send_request(32'hDEAD_BEEF, 6'd37);
        send_request(32'hDEAD_BEEF, 6'd63);
    endtask

    // Top digit of each range: '9', 'A', 'Z', and a carry into two digits
    task automatic test_digit_boundaries();
        send_request(32'd9, 6'd10);
        send_request(32'd10, 6'd11);
        send_request(32'd35, 6'd36);
        send_request(32'd36, 6'd36);
    endtask

    task automatic test_random_requests();
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // re-pick the idling pattern every few dozen requests
            if (n % 40 == 0) begin
                tx_throttle = ($urandom_range(0, 3) != 0);
                rx_throttle = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 3))
                0:       value = $urandom_range(0, 1500);
                1:       value = $urandom & 32'h0000_FFFF;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0) begin
                radix = RADIX_BITS'($urandom_range(0, 63));
            end else begin
                radix = RADIX_BITS'($urandom_range(2, 36));
            end
            send_request(value, radix);
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_req   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_value();
        test_value_extremes();
        test_radix_clamp();
        test_digit_boundaries();
        test_random_requests();

        // drain: wait for every digit, then a little longer for strays
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_digits.size() != 0) @(posedge aclk);
        repeat (2 * (VALUE_BITS + 2)) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("unsigned_to_ascii_radix verification clean");
        end else begin
            $display("unsigned_to_ascii_radix verification failed");
        end
        $finish;
    end

endmodule
